// ===== rtl/pbf_pkg.sv =====
// ----------------------------------------------------------------------------
// pbf_pkg
// Types and constants shared by the protobuf wire-format field parser.
// ----------------------------------------------------------------------------
`default_nettype none

package pbf_pkg;

   localparam int DEFAULT_MAX_BUFFER = 65536;

   // a varint carries at most ten 7-bit groups
   localparam int VARINT_GROUPS = 10;

   localparam logic [2:0] WIRE_VARINT = 3'd0;
   localparam logic [2:0] WIRE_I64    = 3'd1;
   localparam logic [2:0] WIRE_LEN    = 3'd2;
   localparam logic [2:0] WIRE_I32    = 3'd5;

   localparam logic [15:0] I32_BYTES = 16'd4;
   localparam logic [15:0] I64_BYTES = 16'd8;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_TRUNC = 2'd1,
      STATUS_LONG  = 2'd2,
      STATUS_WIRE  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PHASE_TAG    = 2'd0,
      PHASE_VALUE  = 2'd1,
      PHASE_LENGTH = 2'd2,
      PHASE_SKIP   = 2'd3
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] field_number;
      logic [2:0]  wire_type;
      logic [63:0] varint_value;
      logic [15:0] payload_offset;
      logic [15:0] payload_length;
      logic        ends_buffer;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ===== rtl/pbf_stream_if.sv =====
// ----------------------------------------------------------------------------
// pbf_stream_if
// Valid/ready stream channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbf_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/protobuf_field_parser_core.sv =====
// ----------------------------------------------------------------------------
// protobuf_field_parser_core
// Streaming protobuf wire-format decoder, one buffer byte per beat.
// ----------------------------------------------------------------------------
// req_chan carries one buffer byte per beat plus a last_byte flag on the final
// byte. rsp_chan returns one beat per completed field (field number, wire
// type, varint value, payload offset and length) or per error (truncated,
// varint too long, unsupported wire type). After an error the remaining bytes
// of the buffer are consumed silently; the last byte always returns the parser
// to its reset state.
// Throughput: one byte per cycle, sustained while rsp_chan takes results. The
// byte goes into an input register, the decode state is updated from it, and
// any result lands in the output register, from which it is offered on
// rsp_chan.
// When rsp_chan stalls, bytes that produce no result keep flowing; a byte that
// produces a result waits in the input register, with req_chan.ready low,
// until the output register frees.
// Reset (synchronous, active high) empties both registers and puts the parser
// at the start of a buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module protobuf_field_parser_core import pbf_pkg::*; #(
   parameter int MAX_BUFFER = DEFAULT_MAX_BUFFER
) (
   input  wire logic    clock,
   input  wire logic    reset,
   pbf_stream_if.sink   req_chan,
   pbf_stream_if.source rsp_chan
);

   logic            res_valid;
   logic            res_ready;
   rsp_payload_type res_beat;

   pbf_decode #(
      .MAX_BUFFER (MAX_BUFFER)
   ) u_decode (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .res_valid (res_valid),
      .res_beat  (res_beat),
      .res_ready (res_ready)
   );

   pbf_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .in_valid (res_valid),
      .in_beat  (res_beat),
      .in_ready (res_ready),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== rtl/pbf_decode.sv =====
// ----------------------------------------------------------------------------
// pbf_decode
// Input beat register and field decode state; one byte retired per cycle unless a result waits for the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pbf_decode import pbf_pkg::*; #(
   parameter int MAX_BUFFER = DEFAULT_MAX_BUFFER
) (
   input  wire logic       clock,
   input  wire logic       reset,
   pbf_stream_if.sink      req_chan,
   output logic            res_valid,
   output rsp_payload_type res_beat,
   input  wire logic       res_ready
);

   localparam logic [16:0] MaxBuf = 17'(MAX_BUFFER);

   logic            s1_valid_ff;
   req_payload_type s1_beat_ff;
   logic            s1_fire;

   phase_type   phase_ff, phase_upd, phase_in;
   logic [63:0] acc_ff, acc_upd, acc_in;
   logic [3:0]  gcount_ff, gcount_upd, gcount_in;
   logic [31:0] held_field_ff, held_field_upd, held_field_in;
   logic [2:0]  held_wire_ff, held_wire_upd, held_wire_in;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] vstart_ff, vstart_upd, vstart_in;
   logic [15:0] remain_ff, remain_upd, remain_in;
   logic        err_ff, err_upd, err_in;

   logic [7:0]  byte_c;
   logic        last_c;
   logic [15:0] pos_next;
   logic [63:0] acc_lane;
   logic [63:0] acc_new;
   logic        v_done, v_long;
   logic [16:0] after_len;
   logic [16:0] avail;
   logic        len_big;
   logic        emit_c;
   status_type  status_c;

   assign byte_c   = s1_beat_ff.data_byte;
   assign last_c   = s1_beat_ff.last_byte;
   assign pos_next = pos_ff + 16'd1;

   // place the 7-bit group at its lane; the tenth group keeps only bit 0
   always_comb begin
      acc_lane = '0;
      for (int g = 0; g < VARINT_GROUPS - 1; g++) begin
         if (gcount_ff == 4'(g)) acc_lane[7*g +: 7] = byte_c[6:0];
      end
      if (gcount_ff == 4'(VARINT_GROUPS - 1)) acc_lane[63] = byte_c[0];
   end

   assign acc_new = acc_ff | acc_lane;
   assign v_done  = !byte_c[7];
   assign v_long  = byte_c[7] && (gcount_ff >= 4'(VARINT_GROUPS - 1));

   assign after_len = {1'b0, pos_ff} + 17'd1;
   assign avail     = (MaxBuf > after_len) ? (MaxBuf - after_len) : '0;
   assign len_big   = (|acc_new[63:17]) || (acc_new[16:0] > avail);

   // next state
   always_comb begin
      phase_upd      = phase_ff;
      acc_upd        = acc_ff;
      gcount_upd     = gcount_ff;
      held_field_upd = held_field_ff;
      held_wire_upd  = held_wire_ff;
      vstart_upd     = vstart_ff;
      remain_upd     = remain_ff;
      err_upd        = err_ff;
      emit_c         = 1'b0;
      status_c       = STATUS_OK;

      if (!err_ff) begin
         unique case (phase_ff)
            PHASE_TAG: begin
               if (v_long) begin
                  emit_c   = 1'b1;
                  status_c = STATUS_LONG;
                  err_upd  = 1'b1;
               end else if (v_done) begin
                  held_field_upd = acc_new[34:3];
                  held_wire_upd  = acc_new[2:0];
                  acc_upd        = '0;
                  gcount_upd     = '0;
                  vstart_upd     = pos_next;
                  priority if (acc_new[2:0] == WIRE_VARINT) begin
                     phase_upd = PHASE_VALUE;
                  end else if (acc_new[2:0] == WIRE_LEN) begin
                     phase_upd = PHASE_LENGTH;
                  end else if (acc_new[2:0] == WIRE_I32) begin
                     remain_upd = I32_BYTES;
                     phase_upd  = PHASE_SKIP;
                  end else if (acc_new[2:0] == WIRE_I64) begin
                     remain_upd = I64_BYTES;
                     phase_upd  = PHASE_SKIP;
                  end else begin
                     emit_c   = 1'b1;
                     status_c = STATUS_WIRE;
                     err_upd  = 1'b1;
                  end
               end else begin
                  acc_upd    = acc_new;
                  gcount_upd = gcount_ff + 4'd1;
                  if (gcount_ff == '0) begin
                     held_field_upd = '0;
                     held_wire_upd  = '0;
                  end
               end
            end
            PHASE_VALUE: begin
               if (v_long) begin
                  emit_c   = 1'b1;
                  status_c = STATUS_LONG;
                  err_upd  = 1'b1;
               end else if (v_done) begin
                  emit_c     = 1'b1;
                  acc_upd    = '0;
                  gcount_upd = '0;
                  phase_upd  = PHASE_TAG;
               end else begin
                  acc_upd    = acc_new;
                  gcount_upd = gcount_ff + 4'd1;
               end
            end
            PHASE_LENGTH: begin
               if (v_long) begin
                  emit_c   = 1'b1;
                  status_c = STATUS_LONG;
                  err_upd  = 1'b1;
               end else if (v_done) begin
                  acc_upd    = '0;
                  gcount_upd = '0;
                  vstart_upd = pos_next;
                  if (len_big) begin
                     emit_c   = 1'b1;
                     status_c = STATUS_TRUNC;
                     err_upd  = 1'b1;
                  end else if (acc_new == '0) begin
                     emit_c    = 1'b1;
                     phase_upd = PHASE_TAG;
                  end else begin
                     remain_upd = acc_new[15:0];
                     phase_upd  = PHASE_SKIP;
                  end
               end else begin
                  acc_upd    = acc_new;
                  gcount_upd = gcount_ff + 4'd1;
               end
            end
            PHASE_SKIP: begin
               remain_upd = (remain_ff == '0) ? '0 : remain_ff - 16'd1;
               if (remain_ff <= 16'd1) begin
                  emit_c    = 1'b1;
                  phase_upd = PHASE_TAG;
               end
            end
            default: begin
               phase_upd = PHASE_TAG;
            end
         endcase

         // buffer ends inside a field
         if (last_c && !emit_c && (phase_upd != PHASE_TAG || gcount_upd != '0)) begin
            emit_c   = 1'b1;
            status_c = STATUS_TRUNC;
         end
      end

      if (last_c) begin
         phase_in      = PHASE_TAG;
         acc_in        = '0;
         gcount_in     = '0;
         held_field_in = '0;
         held_wire_in  = '0;
         pos_in        = '0;
         vstart_in     = '0;
         remain_in     = '0;
         err_in        = 1'b0;
      end else begin
         phase_in      = phase_upd;
         acc_in        = acc_upd;
         gcount_in     = gcount_upd;
         held_field_in = held_field_upd;
         held_wire_in  = held_wire_upd;
         pos_in        = pos_next;
         vstart_in     = vstart_upd;
         remain_in     = remain_upd;
         err_in        = err_upd;
      end
   end

   // result beat
   always_comb begin
      res_beat                = '0;
      res_beat.status         = status_c;
      res_beat.field_number   = held_field_upd;
      res_beat.wire_type      = held_wire_upd;
      res_beat.ends_buffer    = last_c;
      if (status_c == STATUS_OK) begin
         unique case (phase_ff)
            PHASE_VALUE: begin
               res_beat.varint_value   = acc_new;
               res_beat.payload_offset = vstart_ff;
               res_beat.payload_length = pos_next - vstart_ff;
            end
            PHASE_LENGTH: begin
               res_beat.payload_offset = pos_next;
            end
            PHASE_SKIP: begin
               res_beat.payload_offset = vstart_ff;
               if (held_wire_ff == WIRE_LEN) begin
                  res_beat.payload_length = pos_next - vstart_ff;
               end else if (held_wire_ff == WIRE_I32) begin
                  res_beat.payload_length = I32_BYTES;
               end else begin
                  res_beat.payload_length = I64_BYTES;
               end
            end
            default: begin
               res_beat.payload_offset = '0;
            end
         endcase
      end
   end

   assign res_valid      = s1_valid_ff && emit_c;
   assign s1_fire        = s1_valid_ff && (!emit_c || res_ready);
   assign req_chan.ready = !s1_valid_ff || s1_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
      if (req_chan.valid && req_chan.ready) begin
         s1_beat_ff <= req_chan.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_TAG;
         acc_ff        <= '0;
         gcount_ff     <= '0;
         held_field_ff <= '0;
         held_wire_ff  <= '0;
         pos_ff        <= '0;
         vstart_ff     <= '0;
         remain_ff     <= '0;
         err_ff        <= 1'b0;
      end else if (s1_fire) begin
         phase_ff      <= phase_in;
         acc_ff        <= acc_in;
         gcount_ff     <= gcount_in;
         held_field_ff <= held_field_in;
         held_wire_ff  <= held_wire_in;
         pos_ff        <= pos_in;
         vstart_ff     <= vstart_in;
         remain_ff     <= remain_in;
         err_ff        <= err_in;
      end
   end

   a_skip_has_bytes: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_SKIP |-> remain_ff != '0)
      else $error("skip phase with no bytes left");

   a_group_bound: assert property (@(posedge clock) disable iff (reset)
      gcount_ff < 4'(VARINT_GROUPS))
      else $error("varint group count out of range");

   a_error_latches: assert property (@(posedge clock) disable iff (reset)
      s1_fire && emit_c && status_c != STATUS_OK && !last_c |=> err_ff)
      else $error("error result did not enter skip-to-end");

   a_no_result_while_skipping: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && err_ff |-> !res_valid)
      else $error("result produced after error");

endmodule

`default_nettype wire

// ===== rtl/pbf_out_reg.sv =====
// ----------------------------------------------------------------------------
// pbf_out_reg
// Result register between the decoder and the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module pbf_out_reg import pbf_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire rsp_payload_type  in_beat,
   output logic                  in_ready,
   pbf_stream_if.source          rsp_chan
);

   logic            valid_ff;
   rsp_payload_type beat_ff;

   assign in_ready         = !valid_ff || rsp_chan.ready;
   assign rsp_chan.valid   = valid_ff;
   assign rsp_chan.payload = beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         beat_ff <= in_beat;
      end
   end

endmodule

`default_nettype wire

// ===== verif/pbf_field_checker.sv =====
// ----------------------------------------------------------------------------
// pbf_field_checker
// Watches the byte and field channels of the protobuf field parser, decodes
// every accepted byte with its own copy of the parse state, and compares each
// field beat against the oldest predicted one.
// ----------------------------------------------------------------------------
`default_nettype none

module pbf_field_checker import pbf_pkg::*; #(
   parameter int MAX_BUFFER = DEFAULT_MAX_BUFFER
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_ready,
   input  wire req_payload_type req_payload,
   input  wire logic            rsp_valid,
   input  wire logic            rsp_ready,
   input  wire rsp_payload_type rsp_payload,
   output int unsigned          fields_pending,
   output int unsigned          mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   phase_type   phase;
   logic [63:0] acc;
   logic [3:0]  groups;
   logic [31:0] field_num;
   logic [2:0]  tag_wire;
   logic [15:0] pos;
   logic [15:0] value_start;
   logic [16:0] remaining;
   logic        skipping;

   rsp_payload_type expected_fields[$];

   function automatic void clear_varint();
      acc    = '0;
      groups = '0;
   endfunction

   function automatic void clear_parse();
      phase = PHASE_TAG;
      clear_varint();
      field_num   = '0;
      tag_wire    = '0;
      pos         = '0;
      value_start = '0;
      remaining   = '0;
      skipping    = 1'b0;
   endfunction

   // 1: varint done, 0: more groups follow, -1: too long
   function automatic int varint_step(input logic [7:0] b);
      acc = acc | ({57'd0, b[6:0]} << (7 * groups));
      if (!b[7]) return 1;
      if (groups >= 4'd9) return -1;
      groups = groups + 4'd1;
      return 0;
   endfunction

   function automatic void queue_field(input status_type st, input logic [63:0] value,
                                       input logic [15:0] offset, input logic [15:0] length,
                                       input logic is_last);
      rsp_payload_type res;
      res.status         = st;
      res.field_number   = field_num;
      res.wire_type      = tag_wire;
      res.varint_value   = value;
      res.payload_offset = offset;
      res.payload_length = length;
      res.ends_buffer    = is_last;
      expected_fields.push_back(res);
   endfunction

   function automatic void parse_byte(input logic [7:0] b, input logic is_last);
      logic [15:0] next_pos;
      logic [63:0] avail;
      logic [63:0] len;
      logic [15:0] span;
      int          after;
      int          r;
      bit          hit;
      next_pos = pos + 16'd1;
      hit      = 1'b0;
      if (skipping) begin
         if (is_last) clear_parse();
         else pos = next_pos;
         return;
      end
      case (phase)
         PHASE_TAG: begin
            if (groups == 4'd0) begin
               field_num = '0;
               tag_wire  = '0;
            end
            r = varint_step(b);
            if (r < 0) begin
               queue_field(STATUS_LONG, '0, '0, '0, is_last);
               hit      = 1'b1;
               skipping = 1'b1;
            end else if (r > 0) begin
               field_num = acc[34:3];
               tag_wire  = acc[2:0];
               clear_varint();
               value_start = next_pos;
               case (tag_wire)
                  WIRE_VARINT: phase = PHASE_VALUE;
                  WIRE_LEN:    phase = PHASE_LENGTH;
                  WIRE_I32: begin
                     remaining = {1'b0, I32_BYTES};
                     phase     = PHASE_SKIP;
                  end
                  WIRE_I64: begin
                     remaining = {1'b0, I64_BYTES};
                     phase     = PHASE_SKIP;
                  end
                  default: begin
                     queue_field(STATUS_WIRE, '0, '0, '0, is_last);
                     hit      = 1'b1;
                     skipping = 1'b1;
                  end
               endcase
            end
         end
         PHASE_VALUE: begin
            r = varint_step(b);
            if (r < 0) begin
               queue_field(STATUS_LONG, '0, '0, '0, is_last);
               hit      = 1'b1;
               skipping = 1'b1;
            end else if (r > 0) begin
               queue_field(STATUS_OK, acc, value_start, next_pos - value_start, is_last);
               hit = 1'b1;
               clear_varint();
               phase = PHASE_TAG;
            end
         end
         PHASE_LENGTH: begin
            r = varint_step(b);
            if (r < 0) begin
               queue_field(STATUS_LONG, '0, '0, '0, is_last);
               hit      = 1'b1;
               skipping = 1'b1;
            end else if (r > 0) begin
               // room left in the buffer counts from the wrapped position
               after = int'(pos) + 1;
               avail = (MAX_BUFFER > after) ? 64'(MAX_BUFFER - after) : 64'd0;
               len   = acc;
               clear_varint();
               value_start = next_pos;
               if (len > avail) begin
                  queue_field(STATUS_TRUNC, '0, '0, '0, is_last);
                  hit      = 1'b1;
                  skipping = 1'b1;
               end else if (len == 64'd0) begin
                  queue_field(STATUS_OK, '0, value_start, '0, is_last);
                  hit   = 1'b1;
                  phase = PHASE_TAG;
               end else begin
                  remaining = len[16:0];
                  phase     = PHASE_SKIP;
               end
            end
         end
         default: begin
            if (remaining != '0) remaining = remaining - 17'd1;
            if (remaining == '0) begin
               if (tag_wire == WIRE_LEN) span = next_pos - value_start;
               else if (tag_wire == WIRE_I32) span = I32_BYTES;
               else span = I64_BYTES;
               queue_field(STATUS_OK, '0, value_start, span, is_last);
               hit   = 1'b1;
               phase = PHASE_TAG;
            end
         end
      endcase
      if (is_last) begin
         if (!hit && (phase != PHASE_TAG || groups != 4'd0))
            queue_field(STATUS_TRUNC, '0, '0, '0, 1'b1);
         clear_parse();
      end else begin
         pos = next_pos;
      end
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         clear_parse();
         expected_fields.delete();
         mismatch_count = 0;
      end else begin
         if (req_valid && req_ready)
            parse_byte(req_payload.data_byte, req_payload.last_byte);
         if (rsp_valid && rsp_ready) begin
            if (expected_fields.size() == 0) begin
               $error("field beat with none expected: status %0d field %0d",
                      rsp_payload.status, rsp_payload.field_number);
               mismatch_count++;
            end else begin
               want = expected_fields.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_payload.status));
               check_field("field_number", 64'(want.field_number),
                           64'(rsp_payload.field_number));
               check_field("wire_type", 64'(want.wire_type), 64'(rsp_payload.wire_type));
               check_field("varint_value", want.varint_value, rsp_payload.varint_value);
               check_field("payload_offset", 64'(want.payload_offset),
                           64'(rsp_payload.payload_offset));
               check_field("payload_length", 64'(want.payload_length),
                           64'(rsp_payload.payload_length));
               check_field("ends_buffer", 64'(want.ends_buffer), 64'(rsp_payload.ends_buffer));
            end
         end
      end
      fields_pending = expected_fields.size();
   end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Feeds encoded protobuf buffers into the field parser one byte per beat:
// a few hand-built buffers and a few hundred bytes of random well-formed and
// broken buffers.
// Both channels idle at random; the checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import pbf_pkg::*;

   localparam int RANDOM_BYTES = 320;
   localparam int CYCLE_LIMIT  = 20000;
   localparam int QUIET_FROM   = 150;
   localparam int QUIET_TO     = 350;

   logic clock;
   logic reset;
   int   cycle_count = 0;
   int   bytes_sent  = 0;

   int unsigned fields_pending;
   int unsigned mismatch_count;

   logic [7:0]      frame_bytes[$];
   req_payload_type byte_feed[$];

   pbf_stream_if #(.payload_type(req_payload_type)) req_chan ();
   pbf_stream_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   protobuf_field_parser_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   pbf_field_checker #(.MAX_BUFFER(DEFAULT_MAX_BUFFER)) field_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_payload    (req_chan.payload),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_payload    (rsp_chan.payload),
      .fields_pending (fields_pending),
      .mismatch_count (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---- buffer building ----------------------------------------------------

   function automatic logic [63:0] random_wide();
      return {$urandom, $urandom} >> $urandom_range(0, 63);
   endfunction

   function automatic void put_varint(input logic [63:0] v);
      do begin
         frame_bytes.push_back({(v > 64'h7F), v[6:0]});
         v = v >> 7;
      end while (v != 64'd0);
   endfunction

   function automatic void put_noise(input int count);
      repeat (count) frame_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic void put_field();
      logic [2:0]  wt;
      logic [63:0] fnum;
      int          n;
      case ($urandom_range(0, 3))
         0: wt = WIRE_VARINT;
         1: wt = WIRE_I64;
         2: wt = WIRE_LEN;
         default: wt = WIRE_I32;
      endcase
      fnum = random_wide();
      if ($urandom_range(0, 3) != 0) fnum = 64'($urandom_range(1, 40));
      put_varint({fnum[60:0], wt});
      case (wt)
         WIRE_VARINT: put_varint(random_wide());
         WIRE_LEN: begin
            n = $urandom_range(0, 12);
            put_varint(64'(n));
            put_noise(n);
         end
         WIRE_I32: put_noise(4);
         default:  put_noise(8);
      endcase
   endfunction

   function automatic void end_frame();
      for (int i = 0; i < frame_bytes.size(); i++)
         byte_feed.push_back('{data_byte: frame_bytes[i],
                               last_byte: (i == frame_bytes.size() - 1)});
      frame_bytes.delete();
   endfunction

   // one random buffer: mostly well-formed, the rest broken in some way
   function automatic void random_frame();
      logic [2:0] bad_wire;
      int         cut;
      repeat ($urandom_range(1, 5)) put_field();
      if ($urandom_range(0, 99) < 30) begin
         case ($urandom_range(0, 4))
            0: begin
               // ends inside a field
               cut = $urandom_range(1, (frame_bytes.size() > 6) ? 6 : frame_bytes.size() - 1);
               repeat (cut) void'(frame_bytes.pop_back());
            end
            1: begin
               case ($urandom_range(0, 3))
                  0: bad_wire = 3'd3;
                  1: bad_wire = 3'd4;
                  2: bad_wire = 3'd6;
                  default: bad_wire = 3'd7;
               endcase
               put_varint({61'($urandom_range(1, 5000)), bad_wire});
               put_noise($urandom_range(0, 4));
            end
            2: begin
               // over-long varint as tag, value or length
               case ($urandom_range(0, 2))
                  0: frame_bytes.push_back({5'd1, WIRE_VARINT});
                  1: frame_bytes.push_back({5'd2, WIRE_LEN});
                  default: ;
               endcase
               repeat ($urandom_range(10, 12))
                  frame_bytes.push_back({1'b1, 7'($urandom_range(0, 127))});
               put_noise($urandom_range(0, 3));
            end
            3: begin
               frame_bytes.push_back({5'd3, WIRE_LEN});
               put_varint(random_wide() | 64'h1_0000);
               put_noise($urandom_range(0, 3));
            end
            default: begin
               frame_bytes.delete();
               put_noise($urandom_range(1, 8));
            end
         endcase
      end
      if (frame_bytes.size() == 0) put_noise(1);
      end_frame();
   endfunction

   function automatic void build_stream();
      int target;
      frame_bytes = '{8'h08, 8'h96, 8'h01};
      end_frame();
      // empty length-delimited field, then a fixed32 closing the buffer
      frame_bytes = '{8'h12, 8'h00, 8'h1D, 8'hAA, 8'hBB, 8'hCC, 8'hDD};
      end_frame();
      // wire type 3, trailing byte is swallowed
      frame_bytes = '{8'h0B, 8'h00};
      end_frame();
      // tag done, value missing
      frame_bytes = '{8'h10};
      end_frame();
      // tag itself cut short
      frame_bytes = '{8'h80};
      end_frame();
      // length of 64K cannot fit
      frame_bytes = '{8'h12, 8'h80, 8'h80, 8'h04};
      end_frame();
      repeat (10) frame_bytes.push_back(8'hFF);
      end_frame();

      target = byte_feed.size() + RANDOM_BYTES;
      while (byte_feed.size() < target) random_frame();
      repeat (4) random_frame();
   endfunction

   // ---- drivers --------------------------------------------------------------

   function automatic bit take_break();
      if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
      return ($urandom_range(0, 99) < 10);
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid) bytes_sent++;
         if (bytes_sent < byte_feed.size() && !take_break()) begin
            req_chan.valid   <= 1'b1;
            req_chan.payload <= byte_feed[bytes_sent];
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= !take_break();
   end

   // ---- run control ----------------------------------------------------------

   initial begin
      reset = 1'b1;
      build_stream();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      do @(negedge clock); while (bytes_sent < byte_feed.size());
      @(negedge clock);
      while (fields_pending != 0) @(negedge clock);
      // leave room for stray beats
      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
